// File: hw/rtl/spra_pkg.sv
package spra_pkg;

    localparam int DATA_W = 8;
    localparam int REQ_W  = 3;
    localparam int CFG_INDEX_W = 8;

    localparam int RING_DEPTH_DEF = 50;

    // Event codes carried in req_type
    localparam logic [REQ_W-1:0] REQ_COMMAND  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DISTANCE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ZERO     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_HALF     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COMPARE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PERIOD   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_POLL     = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_CODE       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LIMIT     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_TURN_COUNT = 8'd3;

    localparam logic [DATA_W-1:0] START_CODE_RST      = 8'd228;
    localparam logic [DATA_W-1:0] STOP_CODE_RST       = 8'd229;
    localparam logic [DATA_W-1:0] PULSE_LIMIT_RST     = 8'd210;
    localparam logic [DATA_W-1:0] HALF_TURN_COUNT_RST = 8'd210;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic              fire_pulse;
        logic              avg_valid;
        logic [DATA_W-1:0] avg_distance;
        logic              start_strobe;
        logic              poll_request;
        logic [DATA_W-1:0] count_now;
        logic              running_now;
        logic              zero_side;
    } out_item_t;

    // Pulse controller state after the current item
    typedef struct packed {
        logic              fire;
        logic [DATA_W-1:0] count;
        logic              running;
        logic              zero_side;
    } ctrl_status_t;

endpackage

// File: hw/rtl/scan_pulse_and_range_average.sv
// Scan platform controller: takes one event item per clock (command byte,
// distance byte, zero or half-turn mark, compare, period or poll tick) while
// the result register is free or drained, and returns exactly one result item
// for each, registered, in the cycle after the item is accepted. The sustained
// rate is one item per cycle while m_ready holds: the running ring sum removes
// any pass over the ring, and the single read port of the distance ring is
// prefetched at the next write position, so a distance item finds its
// outgoing entry ready. The period-tick mean is the ring sum multiplied by a
// fixed reciprocal of RING_DEPTH, exact for every sum. Ring entries start as
// zero through per-entry valid bits cleared at reset, so no clearing pass is
// needed and items are taken straight after reset. Configuration writes are
// taken in any cycle out of reset and are meant to arrive only while the
// block is idle; indexes beyond the four registers are dropped.
module scan_pulse_and_range_average #(
    parameter int RING_DEPTH = spra_pkg::RING_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  spra_pkg::in_item_t               s_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output spra_pkg::out_item_t              m_payload,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spra_pkg::DATA_W-1:0]      cfg_data
);

    import spra_pkg::*;

    logic              accept;
    logic              is_period;
    logic [DATA_W-1:0] avg;
    ctrl_status_t      status;
    out_item_t         out_reg, out_next;
    logic              m_valid_reg;

    // Take a new item whenever the result register is empty or being drained
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = aresetn;
    assign is_period = (s_payload.req_type == REQ_PERIOD);

    spra_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_en   (accept),
        .item      (s_payload),
        .cfg_en    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status)
    );

    // Distance bytes go into the ring; the mean reflects the ring before this item
    spra_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && (s_payload.req_type == REQ_DISTANCE)),
        .wr_data (s_payload.data_byte),
        .avg     (avg)
    );

    // Assemble the result item; the mean reads as zero off a period tick
    always_comb begin
        out_next.fire_pulse   = status.fire;
        out_next.avg_valid    = is_period;
        out_next.avg_distance = is_period ? avg : '0;
        out_next.start_strobe = (s_payload.req_type == REQ_COMPARE);
        out_next.poll_request = (s_payload.req_type == REQ_POLL);
        out_next.count_now    = status.count;
        out_next.running_now  = status.running;
        out_next.zero_side    = status.zero_side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the result while stalled, load a fresh one on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // A zero mark clears the count and flags the zero side
    a_zero_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_payload.req_type == REQ_ZERO)
        |=> m_valid && (m_payload.count_now == '0) && m_payload.zero_side)
        else $error("zero mark did not clear the pulse count");

    // A half-turn mark loads a count and leaves the zero side
    a_half_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_payload.req_type == REQ_HALF)
        |=> m_valid && !m_payload.zero_side && !m_payload.fire_pulse)
        else $error("half-turn mark handled wrongly");

    // At most one of the tick flags per result
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_payload.avg_valid, m_payload.start_strobe,
                              m_payload.poll_request}))
        else $error("more than one tick flag set in a result");

    // A compare tick neither fires a pulse nor moves the count
    a_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_payload.req_type == REQ_COMPARE)
        |=> m_payload.start_strobe && !m_payload.fire_pulse
            && (m_payload.count_now == $past(status.count)))
        else $error("compare tick disturbed the pulse count");

endmodule

// File: hw/rtl/spra_ram.sv
module spra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/spra_ring.sv
module spra_ring #(
    parameter int RING_DEPTH = spra_pkg::RING_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [spra_pkg::DATA_W-1:0] wr_data,
    output logic [spra_pkg::DATA_W-1:0] avg
);

    import spra_pkg::*;

    localparam int POS_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W   = $clog2(255 * RING_DEPTH + 1);
    localparam int SHIFT   = SUM_W + $clog2(RING_DEPTH);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam logic [POS_W-1:0]   POS_LAST = POS_W'(RING_DEPTH - 1);

    logic [POS_W-1:0]      pos_reg, pos_next, rd_addr;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [RING_DEPTH-1:0] valid_reg;
    logic                  byp_reg;
    logic [DATA_W-1:0]     byp_data_reg;
    logic [DATA_W-1:0]     rd_data, old_data;
    logic [PROD_W-1:0]     prod;

    // Entry at the write position, prefetched ahead through the registered read port
    always_comb begin
        if (!valid_reg[pos_reg]) begin
            old_data = '0;
        end else if (byp_reg) begin
            old_data = byp_data_reg;
        end else begin
            old_data = rd_data;
        end
    end

    assign pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    assign rd_addr  = wr_en ? pos_next : pos_reg;
    assign sum_next = sum_reg - SUM_W'(old_data) + SUM_W'(wr_data);

    spra_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= '0;
            byp_reg   <= 1'b0;
        end else begin
            byp_reg <= wr_en && (rd_addr == pos_reg);
            if (wr_en) begin
                pos_reg            <= pos_next;
                sum_reg            <= sum_next;
                valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= wr_data;
    end

    // Divide by the depth through an exact reciprocal
    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign avg  = prod[SHIFT +: DATA_W];

endmodule

// File: hw/rtl/spra_ctrl.sv
module spra_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_en,
    input  spra_pkg::in_item_t               item,
    input  logic                             cfg_en,
    input  logic [spra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spra_pkg::DATA_W-1:0]      cfg_data,
    output spra_pkg::ctrl_status_t           status
);

    import spra_pkg::*;

    logic [DATA_W-1:0] start_code_reg, stop_code_reg, pulse_limit_reg, half_turn_reg;
    logic [DATA_W-1:0] count_reg, count_next;
    logic              on_reg, on_next;
    logic              zero_reg, zero_next;
    logic              fire;

    always_comb begin
        count_next = count_reg;
        on_next    = on_reg;
        zero_next  = zero_reg;
        fire       = 1'b0;
        unique case (item.req_type)
            REQ_COMMAND: begin
                if (item.data_byte == start_code_reg) begin
                    on_next    = 1'b1;
                    fire       = 1'b1;
                    count_next = count_reg + 1'b1;
                end else if (item.data_byte == stop_code_reg) begin
                    on_next = 1'b0;
                end
            end
            REQ_ZERO: begin
                zero_next  = 1'b1;
                count_next = '0;
            end
            REQ_HALF: begin
                zero_next  = 1'b0;
                count_next = half_turn_reg;
            end
            REQ_PERIOD: begin
                if (on_reg && (count_reg < pulse_limit_reg)) begin
                    fire       = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            on_reg          <= 1'b0;
            zero_reg        <= 1'b0;
            start_code_reg  <= START_CODE_RST;
            stop_code_reg   <= STOP_CODE_RST;
            pulse_limit_reg <= PULSE_LIMIT_RST;
            half_turn_reg   <= HALF_TURN_COUNT_RST;
        end else begin
            if (item_en) begin
                count_reg <= count_next;
                on_reg    <= on_next;
                zero_reg  <= zero_next;
            end
            if (cfg_en) begin
                unique case (cfg_index)
                    CFG_START_CODE:      start_code_reg  <= cfg_data;
                    CFG_STOP_CODE:       stop_code_reg   <= cfg_data;
                    CFG_PULSE_LIMIT:     pulse_limit_reg <= cfg_data;
                    CFG_HALF_TURN_COUNT: half_turn_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign status.fire      = fire;
    assign status.count     = count_next;
    assign status.running   = on_next;
    assign status.zero_side = zero_next;

endmodule
